[rtl/core/line_rasterizer_assert.svh]
// Assertion macros for the line rasteriser. They sample on clk_i and are
// disabled while rst_ni is low.
`ifndef LINE_RASTERIZER_ASSERT_SVH
`define LINE_RASTERIZER_ASSERT_SVH

`ifndef SYNTHESIS
`define LR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define LR_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define LR_ASSERT(label, prop, msg)
`define LR_ASSERT_NEVER(label, cond, msg)
`endif

`endif

[rtl/core/lr_pkg.sv]
package lr_pkg;

  localparam int DefScreenWidth  = 320;
  localparam int DefScreenHeight = 240;
  localparam int DefCoordBits    = 12;

  localparam int AddrW    = 32;
  localparam int ColourW  = 16;
  localparam int RowShift = 10;
  localparam int ColShift = 1;

  localparam int QueueDepth = 2;

  typedef enum logic {
    OpLoad = 1'b0,
    OpStep = 1'b1
  } opcode_e;

  typedef struct packed {
    logic active;
    logic pop;
    logic pix_pop;
    logic fin;
  } back_status_t;

  function automatic int cmd_width(input int coord_bits);
    return 6 * coord_bits + 4 + ColourW;
  endfunction

endpackage

[rtl/core/lr_front.sv]
module lr_front #(
  parameter int COORD_BITS = lr_pkg::DefCoordBits
) (
  input  logic                                        opcode_i,
  input  logic signed [COORD_BITS-1:0]                start_x_i,
  input  logic signed [COORD_BITS-1:0]                start_y_i,
  input  logic signed [COORD_BITS-1:0]                end_x_i,
  input  logic signed [COORD_BITS-1:0]                end_y_i,
  input  logic        [lr_pkg::ColourW-1:0]           colour_i,
  output logic        [lr_pkg::cmd_width(COORD_BITS)-1:0] cmd_o
);
  import lr_pkg::*;

  localparam int C = COORD_BITS;

  typedef struct packed {
    opcode_e              op;
    logic                 steep;
    logic                 minor_down;
    logic signed [C-1:0]  major_start;
    logic signed [C-1:0]  minor_start;
    logic signed [C-1:0]  major_end;
    logic        [C-1:0]  delta_major;
    logic        [C-1:0]  delta_minor;
    logic signed [C:0]    err_init;
    logic [ColourW-1:0]   colour;
  } cmd_t;

  cmd_t               cmd;
  logic signed [C:0]  dx, dy, ndx, ndy, dm, dn;
  logic        [C-1:0] adx, ady, dmaj, dmin;
  logic               steep, swap;

  always_comb begin
    dx  = (C+1)'(end_x_i) - (C+1)'(start_x_i);
    dy  = (C+1)'(end_y_i) - (C+1)'(start_y_i);
    ndx = -dx;
    ndy = -dy;
    adx = dx[C] ? ndx[C-1:0] : dx[C-1:0];
    ady = dy[C] ? ndy[C-1:0] : dy[C-1:0];

    // Equal magnitudes count as shallow.
    steep = ady > adx;
    dm    = steep ? dy : dx;
    dn    = steep ? dx : dy;
    swap  = dm[C];
    dmaj  = steep ? ady : adx;
    dmin  = steep ? adx : ady;

    cmd.op          = opcode_e'(opcode_i);
    cmd.steep       = steep;
    cmd.major_start = swap ? (steep ? end_y_i : end_x_i) : (steep ? start_y_i : start_x_i);
    cmd.minor_start = swap ? (steep ? end_x_i : end_y_i) : (steep ? start_x_i : start_y_i);
    cmd.major_end   = swap ? (steep ? start_y_i : start_x_i) : (steep ? end_y_i : end_x_i);
    cmd.delta_major = dmaj;
    cmd.delta_minor = dmin;
    cmd.minor_down  = swap ? !dn[C] : (dn[C] || (dn == '0));
    cmd.err_init    = (C+1)'(0) - (C+1)'(dmaj >> 1);
    cmd.colour      = colour_i;
  end

  assign cmd_o = cmd;

endmodule

[rtl/core/lr_queue.sv]
module lr_queue #(
  parameter int DATA_W = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [DATA_W-1:0] push_data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              head_valid_o,
  output logic [DATA_W-1:0] head_data_o
);
  import lr_pkg::*;

  localparam int PtrW = $clog2(QueueDepth);
  localparam int CntW = $clog2(QueueDepth + 1);

  logic [DATA_W-1:0] entry_q [QueueDepth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;
  logic              do_push, do_pop;

  assign full_o       = (count_q == CntW'(QueueDepth));
  assign head_valid_o = (count_q != '0);
  assign head_data_o  = entry_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + PtrW'(1) : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + PtrW'(1) : rd_ptr_q;
    count_d  = count_q + CntW'(do_push) - CntW'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

[rtl/core/lr_back.sv]
module lr_back #(
  parameter int SCREEN_WIDTH  = lr_pkg::DefScreenWidth,
  parameter int SCREEN_HEIGHT = lr_pkg::DefScreenHeight,
  parameter int COORD_BITS    = lr_pkg::DefCoordBits
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic [lr_pkg::AddrW-1:0]                    frame_base_i,
  input  logic                                        head_valid_i,
  input  logic [lr_pkg::cmd_width(COORD_BITS)-1:0]    head_data_i,
  output logic                                        pop_o,
  output lr_pkg::back_status_t                        status_o,
  output logic                                        out_valid_o,
  input  logic                                        out_stall_i,
  output logic signed [COORD_BITS-1:0]                pixel_x_o,
  output logic signed [COORD_BITS-1:0]                pixel_y_o,
  output logic        [lr_pkg::AddrW-1:0]             pixel_address_o,
  output logic        [lr_pkg::ColourW-1:0]           pixel_colour_o,
  output logic                                        write_enable_o,
  output logic                                        last_o
);
  import lr_pkg::*;

  localparam int C = COORD_BITS;
  localparam logic [AddrW-1:0] ScrW = AddrW'(SCREEN_WIDTH);
  localparam logic [AddrW-1:0] ScrH = AddrW'(SCREEN_HEIGHT);

  typedef struct packed {
    opcode_e              op;
    logic                 steep;
    logic                 minor_down;
    logic signed [C-1:0]  major_start;
    logic signed [C-1:0]  minor_start;
    logic signed [C-1:0]  major_end;
    logic        [C-1:0]  delta_major;
    logic        [C-1:0]  delta_minor;
    logic signed [C:0]    err_init;
    logic [ColourW-1:0]   colour;
  } cmd_t;

  cmd_t cmd;

  logic signed [C-1:0]  major_q, minor_q, end_q;
  logic signed [C:0]    err_q;
  logic        [C-1:0]  dmaj_q, dmin_q;
  logic                 down_q, steep_q, active_q;
  logic [ColourW-1:0]   colour_q;

  logic                 out_valid_q, out_valid_d;
  logic signed [C-1:0]  px_q, py_q;
  logic [AddrW-1:0]     addr_q;
  logic [ColourW-1:0]   pcol_q;
  logic                 we_q, last_q;

  logic signed [C-1:0]  px, py;
  logic signed [C:0]    err_sum, err_next;
  logic [AddrW-1:0]     px_ext, py_ext, addr;
  logic                 fin, we, is_step, out_free, pop, pix_pop;

  assign cmd = cmd_t'(head_data_i);

  always_comb begin
    is_step  = (cmd.op == OpStep);
    out_free = !out_valid_q || !out_stall_i;
    pop      = head_valid_i && (!is_step || !active_q || out_free);
    pix_pop  = head_valid_i && is_step && active_q && out_free;

    px      = steep_q ? minor_q : major_q;
    py      = steep_q ? major_q : minor_q;
    px_ext  = AddrW'(px);
    py_ext  = AddrW'(py);
    addr    = frame_base_i + (py_ext << RowShift) + (px_ext << ColShift);
    we      = !px[C-1] && !py[C-1] && (px_ext < ScrW) && (py_ext < ScrH);
    fin     = (major_q >= end_q);

    err_sum  = err_q + $signed({1'b0, dmin_q});
    err_next = (err_sum > 0) ? err_sum - $signed({1'b0, dmaj_q}) : err_sum;

    if (pix_pop) begin
      out_valid_d = 1'b1;
    end else if (out_stall_i) begin
      out_valid_d = out_valid_q;
    end else begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
      major_q     <= '0;
      minor_q     <= '0;
      end_q       <= '0;
      err_q       <= '0;
      dmaj_q      <= '0;
      dmin_q      <= '0;
      down_q      <= 1'b0;
      steep_q     <= 1'b0;
      colour_q    <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      if (pop && !is_step) begin
        major_q  <= cmd.major_start;
        minor_q  <= cmd.minor_start;
        end_q    <= cmd.major_end;
        err_q    <= cmd.err_init;
        dmaj_q   <= cmd.delta_major;
        dmin_q   <= cmd.delta_minor;
        down_q   <= cmd.minor_down;
        steep_q  <= cmd.steep;
        colour_q <= cmd.colour;
        active_q <= 1'b1;
      end else if (pix_pop) begin
        if (fin) begin
          active_q <= 1'b0;
        end else begin
          major_q <= major_q + C'(1);
          err_q   <= err_next;
          if (err_sum > 0) begin
            minor_q <= down_q ? minor_q - C'(1) : minor_q + C'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pix_pop) begin
      px_q   <= px;
      py_q   <= py;
      addr_q <= addr;
      pcol_q <= colour_q;
      we_q   <= we;
      last_q <= fin;
    end
  end

  assign pop_o            = pop;
  assign status_o.active  = active_q;
  assign status_o.pop     = pop;
  assign status_o.pix_pop = pix_pop;
  assign status_o.fin     = fin;

  assign out_valid_o     = out_valid_q;
  assign pixel_x_o       = px_q;
  assign pixel_y_o       = py_q;
  assign pixel_address_o = addr_q;
  assign pixel_colour_o  = pcol_q;
  assign write_enable_o  = we_q;
  assign last_o          = last_q;

endmodule

[rtl/core/line_rasterizer.sv]
// Bresenham line rasteriser for a 16-bit frame buffer.
// The input channel (in_valid_i / in_stall_o) takes one word per cycle while
// in_stall_o is low: an opcode of 0 loads a new line from the endpoint and
// colour fields, an opcode of 1 asks for the next pixel. A load gives no
// output word, and neither does a step while no line is active. A new load
// replaces any line in progress. Each step on an active line gives one output
// word (out_valid_o / out_stall_i) with the pixel position, its byte address,
// the colour, a write enable for pixels inside the visible screen and a last
// flag on the final pixel of the line.
// The frame base address is written through the cfg channel, which is always
// ready; it should only change while the block is idle.
// An accepted word is classified and placed in a two-entry queue at the same
// edge; the pixel stage pops one word per cycle, holding back a step while the
// output word stalls, and loads the pixel of a step into the output register
// at the next edge, so the block sustains one pixel per cycle while the
// receiver does not stall. When the receiver stalls, the output word holds,
// the queue fills and in_stall_o rises once both entries are occupied.
// Reset clears the frame base to zero and leaves no line active.
module line_rasterizer #(
  parameter int SCREEN_WIDTH  = lr_pkg::DefScreenWidth,
  parameter int SCREEN_HEIGHT = lr_pkg::DefScreenHeight,
  parameter int COORD_BITS    = lr_pkg::DefCoordBits
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [lr_pkg::AddrW-1:0]          cfg_frame_base_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              opcode_i,
  input  logic signed [COORD_BITS-1:0]      start_x_i,
  input  logic signed [COORD_BITS-1:0]      start_y_i,
  input  logic signed [COORD_BITS-1:0]      end_x_i,
  input  logic signed [COORD_BITS-1:0]      end_y_i,
  input  logic [lr_pkg::ColourW-1:0]        colour_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [COORD_BITS-1:0]      pixel_x_o,
  output logic signed [COORD_BITS-1:0]      pixel_y_o,
  output logic [lr_pkg::AddrW-1:0]          pixel_address_o,
  output logic [lr_pkg::ColourW-1:0]        pixel_colour_o,
  output logic                              write_enable_o,
  output logic                              last_o
);
  import lr_pkg::*;

`include "line_rasterizer_assert.svh"

  localparam int CmdW = cmd_width(COORD_BITS);

  logic [AddrW-1:0] frame_base_q;
  logic [CmdW-1:0]  front_cmd, head_data;
  logic             q_full, head_valid, pop;
  back_status_t     back_st;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = q_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_base_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      frame_base_q <= cfg_frame_base_i;
    end
  end

  lr_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .opcode_i  (opcode_i),
    .start_x_i (start_x_i),
    .start_y_i (start_y_i),
    .end_x_i   (end_x_i),
    .end_y_i   (end_y_i),
    .colour_i  (colour_i),
    .cmd_o     (front_cmd)
  );

  lr_queue #(
    .DATA_W (CmdW)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (in_valid_i),
    .push_data_i  (front_cmd),
    .full_o       (q_full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_data_o  (head_data)
  );

  lr_back #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT),
    .COORD_BITS    (COORD_BITS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .frame_base_i    (frame_base_q),
    .head_valid_i    (head_valid),
    .head_data_i     (head_data),
    .pop_o           (pop),
    .status_o        (back_st),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .pixel_x_o       (pixel_x_o),
    .pixel_y_o       (pixel_y_o),
    .pixel_address_o (pixel_address_o),
    .pixel_colour_o  (pixel_colour_o),
    .write_enable_o  (write_enable_o),
    .last_o          (last_o)
  );

  `LR_ASSERT_NEVER(a_pop_empty, back_st.pop && !head_valid, "Pixel stage popped an empty queue.")
  `LR_ASSERT(a_pix_out, back_st.pix_pop |=> out_valid_o, "Pixel was not presented at the output.")
  `LR_ASSERT(a_last_idle, back_st.pix_pop && back_st.fin |=> !back_st.active, "Line still active after its last pixel.")
  `LR_ASSERT(a_last_flag, back_st.pix_pop |=> (last_o == $past(back_st.fin)), "Last flag does not match the line end.")

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps

module tb;
  import lr_pkg::*;

  localparam int CoordW       = DefCoordBits;
  localparam int HoldCycles   = 300;
  localparam int HoldSpacing  = 300;
  localparam int PhaseWords   = 225;
  localparam int SettleCycles = 12;

  typedef logic signed [CoordW-1:0] coord_t;

  typedef struct packed {
    opcode_e            op;
    coord_t             sx;
    coord_t             sy;
    coord_t             ex;
    coord_t             ey;
    logic [ColourW-1:0] colour;
  } line_word_t;

  typedef struct packed {
    coord_t             x;
    coord_t             y;
    logic [AddrW-1:0]   addr;
    logic [ColourW-1:0] colour;
    logic               we;
    logic               last;
  } pixel_t;

  logic               clk_i            = 1'b0;
  logic               rst_ni           = 1'b0;
  logic               cfg_valid_i      = 1'b0;
  logic               cfg_ready_o;
  logic [AddrW-1:0]   cfg_frame_base_i = '0;
  logic               in_valid_i       = 1'b0;
  logic               in_stall_o;
  logic               opcode_i         = 1'b0;
  coord_t             start_x_i        = '0;
  coord_t             start_y_i        = '0;
  coord_t             end_x_i          = '0;
  coord_t             end_y_i          = '0;
  logic [ColourW-1:0] colour_i         = '0;
  logic               out_valid_o;
  logic               out_stall_i      = 1'b0;
  coord_t             pixel_x_o;
  coord_t             pixel_y_o;
  logic [AddrW-1:0]   pixel_address_o;
  logic [ColourW-1:0] pixel_colour_o;
  logic               write_enable_o;
  logic               last_o;

  line_rasterizer DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_frame_base_i (cfg_frame_base_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .opcode_i         (opcode_i),
    .start_x_i        (start_x_i),
    .start_y_i        (start_y_i),
    .end_x_i          (end_x_i),
    .end_y_i          (end_y_i),
    .colour_i         (colour_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .pixel_x_o        (pixel_x_o),
    .pixel_y_o        (pixel_y_o),
    .pixel_address_o  (pixel_address_o),
    .pixel_colour_o   (pixel_colour_o),
    .write_enable_o   (write_enable_o),
    .last_o           (last_o)
  );

  always #4 clk_i = ~clk_i;

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Rasteriser state as the testbench sees it.
  logic [AddrW-1:0]      fb_model   = '0;
  coord_t                maj_pos    = '0;
  coord_t                min_pos    = '0;
  coord_t                maj_end    = '0;
  logic signed [CoordW:0] err_acc   = '0;
  logic [CoordW-1:0]     run_major  = '0;
  logic [CoordW-1:0]     run_minor  = '0;
  logic                  step_down  = 1'b0;
  logic                  steep_line = 1'b0;
  logic                  line_live  = 1'b0;
  logic [ColourW-1:0]    line_col   = '0;
  pixel_t                pixels_due[$];

  line_word_t  pending_words[$];
  line_word_t  cur_word;
  int unsigned words_queued   = 0;
  int unsigned words_accepted = 0;
  int unsigned tx_wait        = 0;
  int unsigned rx_wait        = 0;
  int unsigned hold_left      = 0;
  int unsigned next_hold_at   = 150;
  int unsigned mismatches     = 0;
  bit          gaps_on        = 1'b1;
  bit          line_open      = 1'b0;

  function automatic int mag(input int v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic int rnd_coord();
    return int'($urandom_range(0, 4095)) - 2048;
  endfunction

  function automatic int near_coord();
    if ($urandom_range(0, 3) == 0) return rnd_coord();
    return int'($urandom_range(0, 400)) - 40;
  endfunction

  function automatic int clamp_coord(input int v);
    if (v > 2047) return 2047;
    if (v < -2048) return -2048;
    return v;
  endfunction

  function automatic int unsigned draw_wait();
    if (!gaps_on || $urandom_range(0, 1) == 0) return 0;
    return $urandom_range(0, 10);
  endfunction

  task automatic rasterize_word(input line_word_t w);
    int a0, b0, a1, b1, t, px, py, acc;
    pixel_t pix;
    if (w.op == OpLoad) begin
      steep_line = mag($signed(w.ey) - $signed(w.sy)) > mag($signed(w.ex) - $signed(w.sx));
      if (steep_line) begin
        a0 = $signed(w.sy); b0 = $signed(w.sx); a1 = $signed(w.ey); b1 = $signed(w.ex);
      end else begin
        a0 = $signed(w.sx); b0 = $signed(w.sy); a1 = $signed(w.ex); b1 = $signed(w.ey);
      end
      if (a0 > a1) begin
        t = a0; a0 = a1; a1 = t;
        t = b0; b0 = b1; b1 = t;
      end
      maj_pos   = a0[CoordW-1:0];
      min_pos   = b0[CoordW-1:0];
      maj_end   = a1[CoordW-1:0];
      run_major = CoordW'(a1 - a0);
      run_minor = CoordW'(mag(b1 - b0));
      err_acc   = (CoordW+1)'(-(int'(run_major) / 2));
      step_down = !(b0 < b1);
      line_col  = w.colour;
      line_live = 1'b1;
    end else if (line_live) begin
      px = steep_line ? int'(min_pos) : int'(maj_pos);
      py = steep_line ? int'(maj_pos) : int'(min_pos);
      pix.x      = px[CoordW-1:0];
      pix.y      = py[CoordW-1:0];
      pix.addr   = fb_model + (py << RowShift) + (px << ColShift);
      pix.colour = line_col;
      pix.we     = px >= 0 && px < DefScreenWidth && py >= 0 && py < DefScreenHeight;
      pix.last   = maj_pos >= maj_end;
      pixels_due.push_back(pix);
      if (pix.last) begin
        line_live = 1'b0;
      end else begin
        maj_pos = maj_pos + CoordW'(1);
        acc = int'(err_acc) + int'(run_minor);
        if (acc > 0) begin
          min_pos = step_down ? min_pos - CoordW'(1) : min_pos + CoordW'(1);
          acc = acc - int'(run_major);
        end
        err_acc = acc[CoordW:0];
      end
    end
  endtask

  task automatic report_mismatch(input string what, input logic [AddrW-1:0] got,
                                 input logic [AddrW-1:0] want);
    mismatches++;
    $display("mismatch on %s: got %h, wanted %h at %0t ns", what, got, want, $time);
  endtask

  task automatic push_word(input opcode_e op, input int sx, sy, ex, ey,
                           input logic [ColourW-1:0] col);
    line_word_t w;
    w.op     = op;
    w.sx     = sx[CoordW-1:0];
    w.sy     = sy[CoordW-1:0];
    w.ex     = ex[CoordW-1:0];
    w.ey     = ey[CoordW-1:0];
    w.colour = col;
    pending_words.push_back(w);
    words_queued++;
  endtask

  task automatic push_steps(input int n);
    repeat (n) push_word(OpStep, rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(),
                         ColourW'($urandom_range(0, 65535)));
  endtask

  task automatic add_random_sequence(inout int unsigned count);
    int sx, sy, ex, ey, len, steps, pick, n, spread;
    pick = $urandom_range(0, 9);
    if (pick < 7) begin
      if ($urandom_range(0, 29) == 0) begin
        sx = rnd_coord(); sy = rnd_coord(); ex = rnd_coord(); ey = rnd_coord();
      end else begin
        spread = ($urandom_range(0, 7) == 0) ? 120 : 12;
        sx = near_coord();
        sy = near_coord();
        ex = clamp_coord(sx + int'($urandom_range(0, 2 * spread)) - spread);
        ey = clamp_coord(sy + int'($urandom_range(0, 2 * spread)) - spread);
      end
      len = ((mag(ex - sx) > mag(ey - sy)) ? mag(ex - sx) : mag(ey - sy)) + 1;
      steps = len;
      if ($urandom_range(0, 4) == 0) steps = $urandom_range(0, len - 1);
      if (steps > 48) steps = 48;
      line_open = steps < len;
      push_word(OpLoad, sx, sy, ex, ey, ColourW'($urandom_range(0, 65535)));
      push_steps(steps);
      count += 1 + steps;
    end else if (pick == 7 && !line_open) begin
      push_steps($urandom_range(1, 3));
    end else begin
      n = $urandom_range(1, 2);
      repeat (n) push_word(opcode_e'($urandom_range(0, 1)), rnd_coord(), rnd_coord(),
                           rnd_coord(), rnd_coord(), ColourW'($urandom_range(0, 65535)));
      line_open = 1'b1;
      count += n;
    end
  endtask

  task automatic drain();
    while (words_accepted != words_queued || pixels_due.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : word_driver
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      tx_wait = 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        rasterize_word(cur_word);
        words_accepted++;
        tx_wait = draw_wait();
      end
      if (!(in_valid_i && in_stall_o)) begin
        if (tx_wait > 0) begin
          in_valid_i <= 1'b0;
          tx_wait--;
        end else if (pending_words.size() != 0) begin
          cur_word = pending_words.pop_front();
          in_valid_i <= 1'b1;
          opcode_i   <= cur_word.op;
          start_x_i  <= cur_word.sx;
          start_y_i  <= cur_word.sy;
          end_x_i    <= cur_word.ex;
          end_y_i    <= cur_word.ey;
          colour_i   <= cur_word.colour;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // The receiver holds off now and then for long enough that the block fills and stalls its
  // input word.
  always @(posedge clk_i) begin : long_hold
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (words_accepted >= next_hold_at) begin
      hold_left <= HoldCycles;
      next_hold_at <= next_hold_at + HoldSpacing;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : pixel_monitor
    pixel_t want;
    int unsigned w;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      rx_wait = 0;
    end else begin
      w = rx_wait;
      if (out_valid_o && !out_stall_i) begin
        if (pixels_due.size() == 0) begin
          report_mismatch("pixel word with none due", pixel_address_o, '0);
        end else begin
          want = pixels_due.pop_front();
          if (pixel_x_o !== want.x)
            report_mismatch("pixel_x", AddrW'(pixel_x_o), AddrW'(want.x));
          if (pixel_y_o !== want.y)
            report_mismatch("pixel_y", AddrW'(pixel_y_o), AddrW'(want.y));
          if (pixel_address_o !== want.addr)
            report_mismatch("pixel_address", pixel_address_o, want.addr);
          if (pixel_colour_o !== want.colour)
            report_mismatch("pixel_colour", AddrW'(pixel_colour_o), AddrW'(want.colour));
          if (write_enable_o !== want.we)
            report_mismatch("write_enable", AddrW'(write_enable_o), AddrW'(want.we));
          if (last_o !== want.last)
            report_mismatch("last", AddrW'(last_o), AddrW'(want.last));
        end
        w = draw_wait();
      end
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
      end else if (w > 0) begin
        out_stall_i <= 1'b1;
        w--;
      end else begin
        out_stall_i <= 1'b0;
      end
      rx_wait = w;
    end
  end

  initial begin : stimulus
    int unsigned count;
    logic [AddrW-1:0] bases[4];
    bases = '{32'hFFFF_FFFF, $urandom, 32'h0000_0000, $urandom};
    wait (rst_ni === 1'b1);

    push_steps(1);
    push_word(OpLoad, 0, 0, 0, 0, 16'h0000);
    push_steps(2);
    push_word(OpLoad, 10, 5, 12, 3, 16'h1234);
    push_steps(3);
    push_word(OpLoad, -2048, 2047, 2047, -2048, 16'hFFFF);
    push_steps(2);
    push_word(OpLoad, 2047, 2047, 2045, 2046, 16'hA5A5);
    push_steps(3);
    push_word(OpLoad, -2048, -2048, -2047, -2046, 16'h5A5A);
    push_steps(3);
    push_word(OpLoad, 319, 237, 320, 241, 16'hFFFF);
    push_steps(5);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      @(posedge clk_i);
      cfg_valid_i      <= 1'b1;
      cfg_frame_base_i <= bases[ph];
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
      cfg_valid_i <= 1'b0;
      fb_model = bases[ph];
      gaps_on = (ph != 2);
      count = 0;
      while (count < PhaseWords) add_random_sequence(count);
      drain();
    end

    if (mismatches == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("FAIL");
    $finish;
  end

endmodule
